@@ rtl/kctol_pkg.sv @@
package kctol_pkg;

    // field and register widths
    localparam int unsigned TILE_W  = 15;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned RANK_W  = 16;
    localparam int unsigned VPI_W   = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 15;

    // default virtual grid
    localparam int unsigned VP_ROWS_DEF = 2;
    localparam int unsigned VP_COLS_DEF = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROW_OFFSET     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_COL_OFFSET     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LOWER_TRIANGLE = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GRID_ROWS      = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GRID_COLS      = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_ROWS     = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COLS     = 3'd6;

    typedef struct packed {
        logic [TILE_W-1:0] tile_row;
        logic [TILE_W-1:0] tile_col;
    } t_req;

    typedef struct packed {
        logic              owner_valid;
        logic [RANK_W-1:0] owner_rank;
        logic [VPI_W-1:0]  virtual_process;
    } t_res;

endpackage

@@ rtl/kcyclic_tile_owner_lookup.sv @@
// Owner lookup for a symmetric tiled matrix under a 2D k-cyclic distribution.
// A request is taken in every cycle (busy never rises) and its result appears
// on o_res with o_strobe high for one cycle, once it has passed one input
// register, two chains of 16 divide cells (tile / block size, then / grid
// size), one multiply register, and one register for the virtual-process
// remainders. Results come back in request order and cannot be stalled, so the
// receiver must take every strobe. Configuration writes are always ready and
// must only be issued while no request is in flight.
module kcyclic_tile_owner_lookup
    import kctol_pkg::*;
#(
    parameter int unsigned VP_ROWS = VP_ROWS_DEF,
    parameter int unsigned VP_COLS = VP_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_strobe,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CDAT_W-1:0] i_cfg_data
);

    localparam int unsigned VP_MAX = (VP_ROWS > VP_COLS) ? VP_ROWS : VP_COLS;
    localparam int unsigned VPW    = $clog2(VP_MAX + 1);
    localparam int unsigned VPS_W  = 2 * VPW + 2;

    // configuration registers
    logic [TILE_W-1:0] r_row_offset, r_col_offset;
    logic              r_lower;
    logic [SIZE_W-1:0] r_grid_rows, r_grid_cols, r_block_rows, r_block_cols;
    logic [SIZE_W-1:0] p_eff, q_eff, kr_eff, kc_eff;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_offset <= '0;
            r_col_offset <= '0;
            r_lower      <= 1'b1;
            r_grid_rows  <= SIZE_W'(1);
            r_grid_cols  <= SIZE_W'(1);
            r_block_rows <= SIZE_W'(1);
            r_block_cols <= SIZE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_OFFSET:     r_row_offset <= i_cfg_data;
                CFG_COL_OFFSET:     r_col_offset <= i_cfg_data;
                CFG_LOWER_TRIANGLE: r_lower      <= i_cfg_data[0];
                CFG_GRID_ROWS:      r_grid_rows  <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_COLS:      r_grid_cols  <= i_cfg_data[SIZE_W-1:0];
                CFG_BLOCK_ROWS:     r_block_rows <= i_cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COLS:     r_block_cols <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero size counts as one
    assign p_eff  = (r_grid_rows  == '0) ? SIZE_W'(1) : r_grid_rows;
    assign q_eff  = (r_grid_cols  == '0) ? SIZE_W'(1) : r_grid_cols;
    assign kr_eff = (r_block_rows == '0) ? SIZE_W'(1) : r_block_rows;
    assign kc_eff = (r_block_cols == '0) ? SIZE_W'(1) : r_block_cols;

    // input stage: add offsets, check the stored triangle
    logic               r_vld0;
    logic [COORD_W-1:0] r_m, r_n, n_m, n_n;
    logic               r_ok, n_ok;

    always_comb begin
        n_m  = COORD_W'(i_req.tile_row) + COORD_W'(r_row_offset);
        n_n  = COORD_W'(i_req.tile_col) + COORD_W'(r_col_offset);
        n_ok = r_lower ? (n_m >= n_n) : (n_n >= n_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_n  <= n_n;
        r_ok <= n_ok;
    end

    // first chains: coordinate / block size
    logic               a_vld_r, a_vld_c, a_ok_r, a_ok_c;
    logic [COORD_W-1:0] a_q_r, a_q_c;
    logic [SIZE_W-1:0]  a_rem_r, a_rem_c;

    kctol_div_chain #(.DW(COORD_W), .VW(SIZE_W), .SW(1)) u_blk_row (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_vld0), .i_dividend (r_m), .i_divisor (kr_eff), .i_side (r_ok),
        .o_vld (a_vld_r), .o_quot (a_q_r), .o_rem (a_rem_r), .o_side (a_ok_r)
    );

    kctol_div_chain #(.DW(COORD_W), .VW(SIZE_W), .SW(1)) u_blk_col (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_vld0), .i_dividend (r_n), .i_divisor (kc_eff), .i_side (r_ok),
        .o_vld (a_vld_c), .o_quot (a_q_c), .o_rem (a_rem_c), .o_side (a_ok_c)
    );

    // second chains: block index / grid size, carry in-block offset along
    logic               b_vld_r, b_vld_c;
    logic [COORD_W-1:0] b_q_r, b_q_c;
    logic [SIZE_W-1:0]  b_rem_r, b_rem_c;
    logic [SIZE_W:0]    b_side_r, b_side_c;

    kctol_div_chain #(.DW(COORD_W), .VW(SIZE_W), .SW(SIZE_W+1)) u_grd_row (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (a_vld_r & a_vld_c), .i_dividend (a_q_r), .i_divisor (p_eff),
        .i_side ({a_ok_r & a_ok_c, a_rem_r}),
        .o_vld (b_vld_r), .o_quot (b_q_r), .o_rem (b_rem_r), .o_side (b_side_r)
    );

    kctol_div_chain #(.DW(COORD_W), .VW(SIZE_W), .SW(SIZE_W+1)) u_grd_col (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (a_vld_r & a_vld_c), .i_dividend (a_q_c), .i_divisor (q_eff),
        .i_side ({a_ok_r & a_ok_c, a_rem_c}),
        .o_vld (b_vld_c), .o_quot (b_q_c), .o_rem (b_rem_c), .o_side (b_side_c)
    );

    // multiply stage: local indexes and the row part of the rank
    logic                       r_vld_m, r_ok_m;
    logic [COORD_W-1:0]         r_lm, r_ln;
    logic [2*SIZE_W-1:0]        r_prod;
    logic [SIZE_W-1:0]          r_col_rank;
    logic [COORD_W+SIZE_W-1:0]  lm_full, ln_full;

    always_comb begin
        lm_full = (COORD_W+SIZE_W)'(b_q_r) * (COORD_W+SIZE_W)'(kr_eff)
                + (COORD_W+SIZE_W)'(b_side_r[SIZE_W-1:0]);
        ln_full = (COORD_W+SIZE_W)'(b_q_c) * (COORD_W+SIZE_W)'(kc_eff)
                + (COORD_W+SIZE_W)'(b_side_c[SIZE_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
        end else begin
            r_vld_m <= b_vld_r & b_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_m     <= b_side_r[SIZE_W] & b_side_c[SIZE_W];
        r_lm       <= lm_full[COORD_W-1:0];
        r_ln       <= ln_full[COORD_W-1:0];
        r_prod     <= (2*SIZE_W)'(b_rem_r) * (2*SIZE_W)'(q_eff);
        r_col_rank <= b_rem_c;
    end

    // finish the rank and saturate it
    logic [2*SIZE_W:0]  rank_sum;
    logic [RANK_W-1:0]  rank_sat;

    always_comb begin
        rank_sum = (2*SIZE_W+1)'(r_prod) + (2*SIZE_W+1)'(r_col_rank);
        rank_sat = (rank_sum > (2*SIZE_W+1)'({RANK_W{1'b1}})) ?
                   {RANK_W{1'b1}} : rank_sum[RANK_W-1:0];
    end

    // remainder stage: local indexes modulo the virtual grid by reciprocal multiply
    localparam int unsigned RS   = COORD_W + 5;
    localparam int unsigned VM_W = COORD_W + RS + 1;
    localparam logic [RS:0] RECIP_R =
        (RS+1)'(((64'd1 << RS) + 64'(VP_ROWS) - 64'd1) / 64'(VP_ROWS));
    localparam logic [RS:0] RECIP_C =
        (RS+1)'(((64'd1 << RS) + 64'(VP_COLS) - 64'd1) / 64'(VP_COLS));

    logic [VM_W-1:0]    vm_r, vm_c;
    logic [COORD_W-1:0] vq_r, vq_c, vr_r, vr_c;
    logic               r_vld_v, r_ok_v;
    logic [RANK_W-1:0]  r_rank_v;
    logic [VPW-1:0]     r_vp_r, r_vp_c;
    logic [VPS_W-1:0]   vp_full;

    always_comb begin
        vm_r = VM_W'(r_lm) * VM_W'(RECIP_R);
        vm_c = VM_W'(r_ln) * VM_W'(RECIP_C);
        vq_r = vm_r[RS +: COORD_W];
        vq_c = vm_c[RS +: COORD_W];
        vr_r = r_lm - COORD_W'(vq_r * COORD_W'(VP_ROWS));
        vr_c = r_ln - COORD_W'(vq_c * COORD_W'(VP_COLS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_v <= 1'b0;
        end else begin
            r_vld_v <= r_vld_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_v   <= r_ok_m;
        r_rank_v <= rank_sat;
        r_vp_r   <= vr_r[VPW-1:0];
        r_vp_c   <= vr_c[VPW-1:0];
    end

    // drive the result, forced for tiles outside the triangle
    always_comb begin
        vp_full  = VPS_W'(r_vp_c) * VPS_W'(VP_ROWS) + VPS_W'(r_vp_r);
        o_strobe = r_vld_v;
        o_res.owner_valid     = r_ok_v;
        o_res.owner_rank      = r_ok_v ? r_rank_v : {RANK_W{1'b1}};
        o_res.virtual_process = r_ok_v ? vp_full[VPI_W-1:0] : '0;
    end

endmodule

@@ rtl/kctol_div_cell.sv @@
module kctol_div_cell
    import kctol_pkg::*;
#(
    parameter int unsigned DW = 16,
    parameter int unsigned VW = 9,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [VW-1:0] i_rem,
    input  logic [DW-1:0] i_work,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [VW-1:0] o_rem,
    output logic [DW-1:0] o_work,
    output logic [SW-1:0] o_side
);

    logic          r_vld;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_work, n_work;
    logic [SW-1:0] r_side;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial  = {i_rem, i_work[DW-1]};
        diff   = trial - {1'b0, i_divisor};
        ge     = (trial >= {1'b0, i_divisor});
        n_rem  = ge ? diff[VW-1:0] : trial[VW-1:0];
        n_work = {i_work[DW-2:0], ge};
    end

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // hand the partial result to the next cell
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_work <= n_work;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_work = r_work;
    assign o_side = r_side;

endmodule

@@ rtl/kctol_div_chain.sv @@
module kctol_div_chain
    import kctol_pkg::*;
#(
    parameter int unsigned DW = 16,
    parameter int unsigned VW = 9,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          vld  [DW+1];
    logic [VW-1:0] rem  [DW+1];
    logic [DW-1:0] work [DW+1];
    logic [SW-1:0] side [DW+1];

    assign vld[0]  = i_vld;
    assign rem[0]  = '0;
    assign work[0] = i_dividend;
    assign side[0] = i_side;

    // one quotient bit per cell, most significant first
    for (genvar g = 0; g < DW; g++) begin : g_cell
        kctol_div_cell #(
            .DW (DW),
            .VW (VW),
            .SW (SW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (vld[g]),
            .i_rem     (rem[g]),
            .i_work    (work[g]),
            .i_divisor (i_divisor),
            .i_side    (side[g]),
            .o_vld     (vld[g+1]),
            .o_rem     (rem[g+1]),
            .o_work    (work[g+1]),
            .o_side    (side[g+1])
        );
    end

    assign o_vld  = vld[DW];
    assign o_quot = work[DW];
    assign o_rem  = rem[DW];
    assign o_side = side[DW];

endmodule
